// ===== hw/rtl/swma_pkg.sv =====
// ----------------------------------------------------------------------------
// swma_pkg
// Shared types and constants for the sliding-window median alert block.
// ----------------------------------------------------------------------------
package swma_pkg;

  // Value range and window size
  localparam int VALUE_BINS = 256;
  localparam int MAX_WINDOW = 1024;

  localparam int SAMPLE_W = 8;
  localparam int BIN_W    = $clog2(VALUE_BINS);
  localparam int PTR_W    = $clog2(MAX_WINDOW);
  localparam int LEN_W    = 11;
  localparam int CNT_W    = 11;
  localparam int MED_W    = 9;
  localparam int ALERT_W  = 32;

  // Result item packing: alert, median_doubled, alert_count, padded to bytes
  localparam int OUT_RAW_W  = 1 + MED_W + ALERT_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_WINDOW_LENGTH = '0;

  // Item sequencer, one-hot
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_INC_RD = 7'b0000100,
    S_INC_WR = 7'b0001000,
    S_DEC_RD = 7'b0010000,
    S_DEC_WR = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

endpackage

// ===== hw/rtl/swma_ram.sv =====
// ----------------------------------------------------------------------------
// swma_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module swma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/sliding_window_median_alert.sv =====
// During warm-up an item goes straight to the histogram update; once the window
// is full, a histogram scan comes first, which reads one bin per cycle through
// the histogram RAM's single read port.
// A new item is accepted in the cycle after the previous result is registered.
// Reset (synchronous) and a window_length write clear the histogram valid bits
// and all counters at once; no clearing pass is needed. window_length resets to 1.
// ----------------------------------------------------------------------------
// sliding_window_median_alert
// Keeps a ring of recent samples and a histogram of them in RAM, finds the
// window median by scanning the histogram, and flags samples at or above
// twice the median.
// ----------------------------------------------------------------------------
module sliding_window_median_alert (
  input  logic                                clk,
  input  logic                                rst,
  // Input items. s_tdata: [7:0] sample_value
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [swma_pkg::SAMPLE_W-1:0]       s_tdata,
  // Result items. m_tdata: [0] alert, [9:1] median_doubled,
  // [41:10] alert_count, zero padding above. m_tuser: [0] window_full
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [swma_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                m_tuser,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swma_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [swma_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [swma_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  import swma_pkg::*;

  state_t state;

  logic [LEN_W-1:0]    window_length;
  logic [LEN_W-1:0]    fill_level;
  logic [PTR_W-1:0]    ring_pointer;
  logic [ALERT_W-1:0]  alerts_so_far;
  logic [VALUE_BINS-1:0] hist_valid;

  logic [SAMPLE_W-1:0] sample;
  logic                full;
  logic                alert;
  logic [MED_W-1:0]    median;

  logic [BIN_W-1:0]    scan_addr;
  logic                rd_pending;
  logic [BIN_W-1:0]    hist_rq;
  logic [CNT_W-1:0]    acc;
  logic                have_lower;
  logic [BIN_W-1:0]    lower;

  logic                cfg_write;
  logic [LEN_W-1:0]    cfg_len;

  logic                hist_we;
  logic [BIN_W-1:0]    hist_waddr;
  logic [CNT_W-1:0]    hist_wdata;
  logic [BIN_W-1:0]    hist_raddr;
  logic [CNT_W-1:0]    hist_rdata;
  logic [CNT_W-1:0]    hist_count;

  logic                ring_we;
  logic [SAMPLE_W-1:0] ring_rdata;

  logic [LEN_W-1:0]    half;
  logic [LEN_W-1:0]    upper_rank;
  logic [LEN_W-1:0]    lower_rank;
  logic [CNT_W-1:0]    acc_next;
  logic                lower_hit;
  logic                upper_hit;
  logic                scan_done;
  logic [BIN_W-1:0]    lower_sel;
  logic [MED_W-1:0]    median_next;

  logic                out_load;
  logic [ALERT_W-1:0]  alerts_next;
  logic [LEN_W-1:0]    ptr_inc;

  // Configuration port: writes clamp window_length into 1..MAX_WINDOW.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[APB_ADDR_W-1:2] == REG_WINDOW_LENGTH);
  assign prdata    = (paddr[APB_ADDR_W-1:2] == REG_WINDOW_LENGTH) ?
                     APB_DATA_W'(window_length) : '0;

  always_comb begin
    cfg_len = pwdata[LEN_W-1:0];
    if (cfg_len == '0) begin
      cfg_len = LEN_W'(1);
    end else if (cfg_len > LEN_W'(MAX_WINDOW)) begin
      cfg_len = LEN_W'(MAX_WINDOW);
    end
  end

  // Histogram and ring memories.
  swma_ram #(.WIDTH(CNT_W), .DEPTH(VALUE_BINS)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  swma_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WINDOW)) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_pointer),
    .wdata (sample),
    .raddr (ring_pointer),
    .rdata (ring_rdata)
  );

  // A bin that was not written since the last clear reads as zero.
  assign hist_count = hist_valid[hist_rq] ? hist_rdata : '0;

  // Histogram read address follows the sequencer step.
  always_comb begin
    case (state)
      S_SCAN:   hist_raddr = scan_addr;
      S_DEC_RD: hist_raddr = BIN_W'(ring_rdata);
      default:  hist_raddr = BIN_W'(sample);
    endcase
  end

  // Histogram write: increment the new bin, then decrement the oldest one.
  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = hist_rq;
    hist_wdata = hist_count;
    case (state)
      S_INC_WR: begin
        hist_we    = 1'b1;
        hist_wdata = hist_count + CNT_W'(1);
      end
      S_DEC_WR: begin
        hist_we    = (hist_count != '0);
        hist_wdata = hist_count - CNT_W'(1);
      end
      default: begin
        hist_we = 1'b0;
      end
    endcase
  end

  // Median ranks and the scan step over one bin.
  assign half       = window_length >> 1;
  assign upper_rank = half + LEN_W'(1);
  assign lower_rank = window_length[0] ? upper_rank : half;
  assign acc_next   = acc + hist_count;
  assign lower_hit  = !have_lower && (acc_next >= lower_rank);
  assign upper_hit  = acc_next >= upper_rank;
  assign scan_done  = rd_pending && (upper_hit || hist_rq == BIN_W'(VALUE_BINS - 1));
  assign lower_sel  = lower_hit ? hist_rq : lower;
  assign median_next = MED_W'(lower_sel) + MED_W'(hist_rq);

  // Result registration and end-of-item bookkeeping.
  assign out_load    = (state == S_OUT) && (!m_tvalid || m_tready);
  assign ring_we     = out_load;
  assign alerts_next = (alert && alerts_so_far != '1) ? alerts_so_far + ALERT_W'(1)
                                                      : alerts_so_far;
  assign ptr_inc     = LEN_W'(ring_pointer) + LEN_W'(1);
  assign s_tready    = (state == S_IDLE);

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    hist_rq <= hist_raddr;
    if (rst) begin
      state         <= S_IDLE;
      window_length <= LEN_W'(1);
      fill_level    <= '0;
      ring_pointer  <= '0;
      alerts_so_far <= '0;
      hist_valid    <= '0;
      m_tvalid      <= 1'b0;
      rd_pending    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      if (hist_we) begin
        hist_valid[hist_waddr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            sample     <= s_tdata;
            full       <= (fill_level >= window_length);
            alert      <= 1'b0;
            median     <= '0;
            scan_addr  <= '0;
            rd_pending <= 1'b0;
            acc        <= '0;
            have_lower <= 1'b0;
            state      <= (fill_level >= window_length) ? S_SCAN : S_INC_RD;
          end
        end
        S_SCAN: begin
          scan_addr  <= scan_addr + BIN_W'(1);
          rd_pending <= !scan_done;
          if (rd_pending) begin
            acc <= acc_next;
            if (lower_hit) begin
              have_lower <= 1'b1;
              lower      <= hist_rq;
            end
          end
          if (scan_done) begin
            median <= median_next;
            alert  <= (MED_W'(sample) >= median_next);
            state  <= S_INC_RD;
          end
        end
        S_INC_RD: begin
          state <= S_INC_WR;
        end
        S_INC_WR: begin
          state <= full ? S_DEC_RD : S_OUT;
        end
        S_DEC_RD: begin
          state <= S_DEC_WR;
        end
        S_DEC_WR: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            m_tvalid      <= 1'b1;
            m_tuser       <= full;
            m_tdata       <= {(OUT_DATA_W - OUT_RAW_W)'(0), alerts_next, median, alert};
            alerts_so_far <= alerts_next;
            if (!full) begin
              fill_level <= fill_level + LEN_W'(1);
            end
            ring_pointer <= (ptr_inc >= window_length) ? '0 : ptr_inc[PTR_W-1:0];
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // A window_length write restarts the window from empty.
      if (cfg_write) begin
        window_length <= cfg_len;
        fill_level    <= '0;
        ring_pointer  <= '0;
        alerts_so_far <= '0;
        hist_valid    <= '0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The window never holds more samples than its length.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_level <= window_length)
    else $error("fill level exceeds window length");

  // The ring pointer stays inside the window.
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    LEN_W'(ring_pointer) < window_length)
    else $error("ring pointer outside window");

  // An accepted item always starts work in the sequencer.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state != S_IDLE)
    else $error("accepted item left sequencer idle");

  // The histogram is only written while an item is in flight.
  a_hist_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !hist_we)
    else $error("histogram written while idle");
`endif

endmodule

// ===== test/sliding_window_median_alert_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_median_alert_tb
// Self-checking bench for the sliding-window median alert block. A scoreboard
// keeps its own ring and histogram, predicts every result item and compares
// it with the block's output. Window lengths are changed over the APB port
// between phases. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------

// One expected result item
typedef struct packed {
  logic                           window_full;
  logic                           alert;
  logic [swma_pkg::MED_W-1:0]     median_doubled;
  logic [swma_pkg::ALERT_W-1:0]   alert_count;
} median_result_t;

// Window predictor and store of expected results
class median_scoreboard;
  logic [swma_pkg::SAMPLE_W-1:0] window_ring [swma_pkg::MAX_WINDOW];
  int unsigned                   value_count [swma_pkg::VALUE_BINS];
  int unsigned                   window_len;
  int unsigned                   fill_level;
  int unsigned                   ring_ptr;
  logic [swma_pkg::ALERT_W-1:0]  alert_total;
  median_result_t                expected_q[$];
  int unsigned                   mismatches;
  int unsigned                   results_checked;
  int unsigned                   alerts_seen;
  int unsigned                   warmup_seen;

  function new();
    window_len = 1;
    mismatches = 0;
    results_checked = 0;
    alerts_seen = 0;
    warmup_seen = 0;
    clear_window();
  endfunction

  function void clear_window();
    foreach (window_ring[i]) window_ring[i] = '0;
    foreach (value_count[i]) value_count[i] = 0;
    fill_level = 0;
    ring_ptr = 0;
    alert_total = '0;
  endfunction

  // A window length write clamps the value and clears all window state.
  function void write_register(logic [swma_pkg::APB_ADDR_W-1:0] addr, logic [31:0] data);
    logic [swma_pkg::LEN_W-1:0] len;
    if (addr[swma_pkg::APB_ADDR_W-1:2] != swma_pkg::REG_WINDOW_LENGTH) return;
    len = data[swma_pkg::LEN_W-1:0];
    if (len == 0) begin
      len = 1;
    end else if (len > swma_pkg::MAX_WINDOW) begin
      len = swma_pkg::MAX_WINDOW;
    end
    window_len = len;
    clear_window();
  endfunction

  // Predict the result of an accepted item and slide the window.
  function void note_sample(logic [swma_pkg::SAMPLE_W-1:0] item_value);
    median_result_t exp_r;
    int unsigned    half, upper_rank, lower_rank, running;
    int unsigned    lower_bin, upper_bin, old_bin, med_sum;
    bit             have_lower, have_upper;
    int             b;
    exp_r = '0;
    if (fill_level >= window_len) begin
      // Scan the histogram upward for the lower and upper middle ranks.
      half = window_len / 2;
      upper_rank = half + 1;
      lower_rank = (window_len % 2) ? upper_rank : half;
      running = 0;
      lower_bin = 0;
      upper_bin = 0;
      have_lower = 0;
      have_upper = 0;
      for (b = 0; b < swma_pkg::VALUE_BINS && !have_upper; b++) begin
        running += value_count[b];
        if (!have_lower && running >= lower_rank) begin
          lower_bin = b;
          have_lower = 1;
        end
        if (running >= upper_rank) begin
          upper_bin = b;
          have_upper = 1;
        end
      end
      med_sum = lower_bin + upper_bin;
      exp_r.window_full = 1'b1;
      exp_r.median_doubled = (med_sum > 511) ? 9'd511 : 9'(med_sum);
      if (item_value >= exp_r.median_doubled) begin
        exp_r.alert = 1'b1;
        if (alert_total != '1) alert_total++;
      end
      // The oldest value leaves as the new one enters.
      old_bin = window_ring[ring_ptr];
      value_count[item_value]++;
      if (value_count[old_bin] > 0) value_count[old_bin]--;
    end else begin
      value_count[item_value]++;
      fill_level++;
    end
    window_ring[ring_ptr] = item_value;
    ring_ptr++;
    if (ring_ptr >= window_len) ring_ptr = 0;
    exp_r.alert_count = alert_total;
    expected_q.insert(expected_q.size(), exp_r);
  endfunction

  // Compare one result item with the oldest expectation.
  function void check_result(logic full, logic alert, logic [swma_pkg::MED_W-1:0] med,
                             logic [swma_pkg::ALERT_W-1:0] count);
    median_result_t exp_r;
    if (expected_q.size() == 0) begin
      $display("%t: unexpected result: full=%0d alert=%0d median_doubled=%0d alert_count=%0d",
               $time, full, alert, med, count);
      mismatches++;
      return;
    end
    exp_r = expected_q.pop_front();
    results_checked++;
    if ({full, alert, med, count} !== exp_r) begin
      $display("%t: mismatch: expected full=%0d alert=%0d median_doubled=%0d alert_count=%0d",
               $time, exp_r.window_full, exp_r.alert, exp_r.median_doubled,
               exp_r.alert_count);
      $display("%t:           actual   full=%0d alert=%0d median_doubled=%0d alert_count=%0d",
               $time, full, alert, med, count);
      mismatches++;
    end
    if (exp_r.alert) alerts_seen++;
    if (!exp_r.window_full) warmup_seen++;
  endfunction
endclass

module sliding_window_median_alert_tb;

  localparam int CYCLE_LIMIT   = 4000000;
  localparam int SETTLE_CYCLES = swma_pkg::VALUE_BINS + 16;

  // Register addresses; the second one maps to no register
  localparam logic [swma_pkg::APB_ADDR_W-3:0] REG_SPARE = 1;
  localparam logic [swma_pkg::APB_ADDR_W-1:0] WINDOW_ADDR = {swma_pkg::REG_WINDOW_LENGTH, 2'b00};
  localparam logic [swma_pkg::APB_ADDR_W-1:0] SPARE_ADDR  = {REG_SPARE, 2'b00};

  // Shapes of random sample streams
  typedef enum int {MIX_UNIFORM, MIX_LOW, MIX_CLUSTER, MIX_ZERO} sample_mix_t;

  logic                              clk      = 1'b0;
  logic                              rst      = 1'b1;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [swma_pkg::SAMPLE_W-1:0]     s_tdata  = '0;   // [7:0] sample_value
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  // [0] alert, [9:1] median_doubled, [41:10] alert_count, zero padding above
  logic [swma_pkg::OUT_DATA_W-1:0]   m_tdata;
  logic                              m_tuser;          // [0] window_full
  logic                              psel     = 1'b0;
  logic                              penable  = 1'b0;
  logic                              pwrite   = 1'b0;
  logic [swma_pkg::APB_ADDR_W-1:0]   paddr    = '0;
  logic [swma_pkg::APB_DATA_W-1:0]   pwdata   = '0;
  logic [swma_pkg::APB_DATA_W-1:0]   prdata;
  logic                              pready;

  median_scoreboard sb = new();
  int unsigned      cycle_count;
  int unsigned      settings_run;
  int unsigned      longest_window;
  int               ready_pct  = 100;
  int               stall_left = 0;

  sliding_window_median_alert uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // 8 ns clock
  initial begin
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** sliding_window_median_alert: FAILED **");
    $finish;
  end

  // Both handshakes are sampled with the values held before the edge.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_sample(s_tdata);
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser, m_tdata[0], m_tdata[1 +: swma_pkg::MED_W],
                      m_tdata[1 + swma_pkg::MED_W +: swma_pkg::ALERT_W]);
  end

  // The receiver changes its readiness level at random intervals.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(3))
        0: ready_pct = 100;
        1: ready_pct = 75;
        2: ready_pct = 30;
        default: ready_pct = 8;
      endcase
      stall_left = $urandom_range(600, 20);
    end else begin
      stall_left = stall_left - 1;
    end
    m_tready <= ($urandom_range(99) < ready_pct);
  end

  // Offer one item and hold it until it is taken.
  task automatic send_item(input logic [swma_pkg::SAMPLE_W-1:0] item_value);
    s_tvalid <= 1'b1;
    s_tdata  <= item_value;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic idle(input int cycles);
    if (cycles > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= swma_pkg::SAMPLE_W'($urandom);
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Hold off the sender until every expected result has come. The first edge
  // lets the last accepted item reach the scoreboard.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [swma_pkg::APB_ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_register(addr, data);
    if (addr == WINDOW_ADDR) begin
      settings_run++;
      if (sb.window_len > longest_window) longest_window = sb.window_len;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pwdata  <= $urandom;
  endtask

  function automatic logic [swma_pkg::SAMPLE_W-1:0] pick_sample(sample_mix_t mix, int base);
    int v;
    case (mix)
      MIX_UNIFORM: v = $urandom_range(255);
      MIX_LOW:     v = ($urandom_range(9) != 0) ? $urandom_range(20) : $urandom_range(255);
      // Mostly near base, with spikes around twice the median.
      MIX_CLUSTER: v = ($urandom_range(6) != 0) ? base + $urandom_range(8)
                                                : 2 * base + $urandom_range(24);
      default:     v = ($urandom_range(9) < 7) ? 0 : $urandom_range(255);
    endcase
    return (v > 255) ? 8'd255 : 8'(v);
  endfunction

  // One window setting with bursts of random items and random gaps.
  task automatic run_phase(input logic [31:0] len_word, input int extra);
    int          remaining, burst, gap, base, i;
    sample_mix_t mix;
    write_reg(WINDOW_ADDR, len_word);
    remaining = sb.window_len + extra;
    base = $urandom_range(120);
    while (remaining > 0) begin
      burst = $urandom_range(24, 1);
      if (burst > remaining) burst = remaining;
      if (sb.window_len > 100) mix = MIX_CLUSTER;
      else mix = sample_mix_t'($urandom_range(3));
      for (i = 0; i < burst; i++) send_item(pick_sample(mix, base));
      remaining -= burst;
      case ($urandom_range(15))
        0, 1, 2, 3: gap = 0;
        14, 15:     gap = $urandom_range(300, 20);
        default:    gap = $urandom_range(10, 1);
      endcase
      idle(gap);
      if ($urandom_range(39) == 0) drain();
    end
    drain();
  endtask

  initial begin
    settings_run = 0;
    longest_window = 1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Window of one after reset: warm-up, then extremes of the sample.
    send_item(8'd0);
    send_item(8'd255);
    send_item(8'd0);
    send_item(8'd255);
    drain();
    // A write to an unmapped address must neither change nor clear the window.
    write_reg(SPARE_ADDR, 32'hFFFF_FFFF);
    send_item(8'd128);
    drain();
    // Even window whose lower median sits in bin zero.
    write_reg(WINDOW_ADDR, 32'd2);
    send_item(8'd0);
    send_item(8'd5);
    send_item(8'd7);
    send_item(8'd3);
    drain();
    // A zero length is stored as one.
    write_reg(WINDOW_ADDR, 32'd0);
    send_item(8'd0);
    send_item(8'd0);
    drain();
    // Upper write bits are ignored; this sets a window of three.
    write_reg(WINDOW_ADDR, 32'hFFFF_F803);
    send_item(8'd255);
    send_item(8'd255);
    send_item(8'd255);
    send_item(8'd255);
    send_item(8'd0);
    send_item(8'd1);
    drain();

    // Random phases over small windows, one oversized write and a random length.
    run_phase(32'd1, 50);
    run_phase(32'd2, 50);
    run_phase(32'd3, 50);
    run_phase(32'd4, 50);
    run_phase(32'd5, 50);
    run_phase(32'd6, 50);
    run_phase(32'd8, 50);
    run_phase(32'd15, 50);
    run_phase(32'd2047, 40);
    run_phase(32'd32, 50);
    run_phase(32'd64, 50);
    run_phase($urandom_range(40, 9), 50);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d results over %0d window settings, lengths 1 to %0d.",
             sb.results_checked, settings_run, longest_window);
    $display("%0d results raised an alert and %0d came during warm-up.",
             sb.alerts_seen, sb.warmup_seen);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("** sliding_window_median_alert: PASSED **");
    end else begin
      $display("** sliding_window_median_alert: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/swma_pkg.sv
hw/rtl/swma_ram.sv
hw/rtl/sliding_window_median_alert.sv
test/sliding_window_median_alert_tb.sv
